>>> rtl/uqbm_pkg.sv
// ----------------------------------------------------------------------------
// uqbm_pkg
// Shared types and constants of the unaligned qword byte memory: controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package uqbm_pkg;

    // byte lanes in one access
    localparam int unsigned LANES = 8;

    // request kinds carried on tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;     // write zeros at the clear counter, step it
        logic accept;     // latch request and issue bank reads
        logic merge_wr;   // write merged words back to both banks
        logic load_out;   // load assembled read beat into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // clear counter at last bank row
        logic is_write;   // latched request is a write
        logic out_free;   // output register can take a beat this cycle
    } t_sts;

endpackage

>>> rtl/uqbm_ram.sv
// ----------------------------------------------------------------------------
// uqbm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds when no read is issued.
// ----------------------------------------------------------------------------
module uqbm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/uqbm_ctrl.sv
// ----------------------------------------------------------------------------
// uqbm_ctrl
// Controller: clearing pass after reset, then an accept / merge sequence
// per request.
// ----------------------------------------------------------------------------
module uqbm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  uqbm_pkg::t_sts  i_sts,
    output uqbm_pkg::t_cmd  o_cmd
);

    uqbm_pkg::t_state r_state;
    uqbm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uqbm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uqbm_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = uqbm_pkg::ST_IDLE;
                end
            end
            uqbm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = uqbm_pkg::ST_MERGE;
                end
            end
            uqbm_pkg::ST_MERGE: begin
                if (i_sts.is_write || i_sts.out_free) begin
                    n_state = uqbm_pkg::ST_IDLE;
                end
            end
            default: n_state = uqbm_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            uqbm_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            uqbm_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            uqbm_pkg::ST_MERGE: begin
                o_cmd.merge_wr = i_sts.is_write;
                o_cmd.load_out = !i_sts.is_write && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/uqbm_dp.sv
// ----------------------------------------------------------------------------
// uqbm_dp
// Datapath: address clamp and decode, even / odd word banks, lane alignment,
// read assembly, write merge and the output register.
// ----------------------------------------------------------------------------
module uqbm_dp #(
    parameter int unsigned MEM_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uqbm_pkg::t_cmd  i_cmd,
    output uqbm_pkg::t_sts  o_sts,
    input  logic            i_req_type,
    input  logic [15:0]     i_byte_address,
    input  logic [63:0]     i_write_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [63:0]     o_read_data
);

    localparam int unsigned ADDR_W      = $clog2(MEM_BYTES);
    localparam int unsigned STORE_WORDS = (MEM_BYTES + 7) / 8;
    localparam int unsigned BANK_DEPTH  = STORE_WORDS / 2 + 1;
    localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);

    // request decode from the incoming beat
    logic [15:0]        in_clamped;
    logic [ADDR_W-1:0]  in_start;
    logic [ADDR_W-1:0]  in_rem;
    logic [ADDR_W-1:0]  in_half;
    logic [BANK_AW-1:0] in_ev_addr;
    logic [BANK_AW-1:0] in_od_addr;

    always_comb begin
        in_clamped = (i_byte_address > 16'(MEM_BYTES - 1)) ? 16'(MEM_BYTES - 1)
                                                           : i_byte_address;
        in_start   = ADDR_W'(in_clamped);
        in_rem     = ADDR_W'(MEM_BYTES - 1) - in_start;
        in_half    = in_start >> 4;
        in_od_addr = BANK_AW'(in_half);
        in_ev_addr = BANK_AW'(in_half + {{(ADDR_W-1){1'b0}}, in_start[3]});
    end

    // latched request
    logic               r_is_write;
    logic [63:0]        r_wdata;
    logic [2:0]         r_off;
    logic               r_par;
    logic               r_sat;
    logic [2:0]         r_last;
    logic [BANK_AW-1:0] r_ev_addr;
    logic [BANK_AW-1:0] r_od_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_write <= (i_req_type == uqbm_pkg::REQ_WRITE);
            r_wdata    <= i_write_data;
            r_off      <= in_start[2:0];
            r_par      <= in_start[3];
            r_sat      <= (in_rem < ADDR_W'(8));
            r_last     <= in_rem[2:0];
            r_ev_addr  <= in_ev_addr;
            r_od_addr  <= in_od_addr;
        end
    end

    // clear counter
    logic [BANK_AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + BANK_AW'(1);
        end
    end

    // word banks
    logic [63:0]        ev_rdata;
    logic [63:0]        od_rdata;
    logic [63:0]        ev_wdata;
    logic [63:0]        od_wdata;
    logic [BANK_AW-1:0] ev_waddr;
    logic [BANK_AW-1:0] od_waddr;
    logic               bank_we;

    uqbm_ram #(
        .WIDTH (64),
        .DEPTH (BANK_DEPTH)
    ) u_ev_bank (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_ev_addr),
        .o_rdata (ev_rdata)
    );

    uqbm_ram #(
        .WIDTH (64),
        .DEPTH (BANK_DEPTH)
    ) u_od_bank (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr (od_waddr),
        .i_wdata (od_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_od_addr),
        .o_rdata (od_rdata)
    );

    // align the two words and assemble / merge lanes
    logic [127:0] pair;
    logic [127:0] pair_sh;
    logic [63:0]  raw;
    logic [7:0]   last_byte;
    logic [63:0]  rd_word;
    logic [7:0]   lane_en;
    logic [63:0]  wr_lanes;
    logic [63:0]  wr_mask;
    logic [127:0] wide_d;
    logic [127:0] wide_m;
    logic [127:0] merged;
    logic [63:0]  new_lo;
    logic [63:0]  new_hi;

    always_comb begin
        pair      = r_par ? {ev_rdata, od_rdata} : {od_rdata, ev_rdata};
        pair_sh   = pair >> {r_off, 3'b000};
        raw       = pair_sh[63:0];
        last_byte = 8'(raw >> {r_last, 3'b000});
        for (int i = 0; i < uqbm_pkg::LANES; i++) begin
            // lanes past the end repeat the last byte of memory
            if (r_sat && (3'(i) > r_last)) begin
                rd_word[8*i +: 8] = last_byte;
            end else begin
                rd_word[8*i +: 8] = raw[8*i +: 8];
            end
            // highest lane lands on the last byte when lanes saturate
            lane_en[i] = !r_sat || (3'(i) <= r_last);
            if (r_sat && (3'(i) == r_last)) begin
                wr_lanes[8*i +: 8] = r_wdata[63:56];
            end else begin
                wr_lanes[8*i +: 8] = r_wdata[8*i +: 8];
            end
            wr_mask[8*i +: 8] = {8{lane_en[i]}};
        end
        wide_d = {64'd0, wr_lanes} << {r_off, 3'b000};
        wide_m = {64'd0, wr_mask} << {r_off, 3'b000};
        merged = (pair & ~wide_m) | (wide_d & wide_m);
        new_lo = merged[63:0];
        new_hi = merged[127:64];
    end

    // bank write select: clearing pass or merge write-back
    always_comb begin
        bank_we = i_cmd.clr_wr || i_cmd.merge_wr;
        if (i_cmd.clr_wr) begin
            ev_waddr = r_clr_cnt;
            od_waddr = r_clr_cnt;
            ev_wdata = '0;
            od_wdata = '0;
        end else begin
            ev_waddr = r_ev_addr;
            od_waddr = r_od_addr;
            ev_wdata = r_par ? new_hi : new_lo;
            od_wdata = r_par ? new_lo : new_hi;
        end
    end

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= rd_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // status
    always_comb begin
        o_sts.clr_last = (r_clr_cnt == BANK_AW'(BANK_DEPTH - 1));
        o_sts.is_write = r_is_write;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

endmodule

>>> rtl/unaligned_qword_byte_memory.sv
// ----------------------------------------------------------------------------
// unaligned_qword_byte_memory
// Byte-addressed memory kept as 64-bit little-endian words in an even and an
// odd bank, serving 8-byte reads and writes at any byte address.
//
//   channel   dir  tdata                                tuser
//   s_axis    in   [15:0] byte_address, [79:16] write   [0] req_type
//                  _data
//   m_axis    out  [63:0] read_data                     -
//
// Each request is accepted, which issues both bank reads, and then the merge
// state merges and writes back (write) or loads the output register (read).
// After reset a clearing pass zeroes one row of both banks per cycle, all
// BANK_DEPTH rows (257 at 4096 bytes), with s_axis_tready low.
// A read waits in the merge cycle while the output register holds an
// untaken beat; a new request is taken meanwhile only after that.
// ----------------------------------------------------------------------------
module unaligned_qword_byte_memory #(
    parameter int unsigned MEM_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // [15:0] byte_address, [79:16] write_data
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] read_data
);

    uqbm_pkg::t_cmd cmd;
    uqbm_pkg::t_sts sts;

    // controller
    uqbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    uqbm_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (s_axis_tuser[0]),
        .i_byte_address (s_axis_tdata[15:0]),
        .i_write_data   (s_axis_tdata[79:16]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_read_data    (m_axis_tdata)
    );

endmodule

>>> rtl/uqbm_chk.sv
// ----------------------------------------------------------------------------
// uqbm_chk
// Port-level checker for the unaligned qword byte memory, bound to the top.
// ----------------------------------------------------------------------------
module uqbm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // one request in flight: an accepted beat closes the input in the cycle after it
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a fresh result beat follows an accepted request through the merge state into the output register
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result beat without a matching request");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind unaligned_qword_byte_memory uqbm_chk u_uqbm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
